>>> rtl/vpdib_pkg.sv
// ----------------------------------------------------------------------------
// vpdib_pkg
// Shared types and constants of the VPD image builder.
// ----------------------------------------------------------------------------
package vpdib_pkg;

	typedef enum logic [2:0] {
		ACT_BEGIN      = 3'd0,
		ACT_ID_HEADER  = 3'd1,
		ACT_ID_BYTE    = 3'd2,
		ACT_RO_HEADER  = 3'd3,
		ACT_KEY_HEADER = 3'd4,
		ACT_VALUE_BYTE = 3'd5,
		ACT_FINISH     = 3'd6,
		ACT_READ       = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_DONE
	} state_t;

	localparam int unsigned WP_W = 17;
	localparam logic [WP_W-1:0] WP_MAX = 17'h1FFFF;

	// Resource tags and fixed bytes of the image.
	localparam logic [7:0] TAG_ID   = 8'h82;
	localparam logic [7:0] TAG_RO   = 8'h90;
	localparam logic [7:0] TAG_END  = 8'h78;
	localparam logic [7:0] KEY_R    = 8'h52;
	localparam logic [7:0] KEY_V    = 8'h56;
	localparam logic [7:0] RV_LEN   = 8'h01;
	localparam logic [7:0] LEN_CLIP = 8'hFF;

	// Byte steps inside one command.
	localparam logic [2:0] HDR_B0       = 3'd0;
	localparam logic [2:0] HDR_B1       = 3'd1;
	localparam logic [2:0] HDR_B2       = 3'd2;
	localparam logic [2:0] FIN_PATCH_LO = 3'd0;
	localparam logic [2:0] FIN_PATCH_HI = 3'd1;
	localparam logic [2:0] FIN_KEY_R    = 3'd2;
	localparam logic [2:0] FIN_KEY_V    = 3'd3;
	localparam logic [2:0] FIN_RV_LEN   = 3'd4;
	localparam logic [2:0] FIN_CHECKSUM = 3'd5;
	localparam logic [2:0] FIN_END_TAG  = 3'd6;

	// Memory write request from the sequencer.
	typedef struct packed {
		logic       we;
		logic [1:0] lane;
		logic [7:0] data;
	} mem_wr_t;

endpackage

>>> rtl/vpdib_if.sv
// ----------------------------------------------------------------------------
// vpdib_if
// Command and response channels of the VPD image builder.
// ----------------------------------------------------------------------------
interface vpdib_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [7:0]  byte_value;
	logic [7:0]  key_first;
	logic [7:0]  key_second;
	logic [15:0] length;
	logic [14:0] address;

	modport source (output valid, action, byte_value, key_first, key_second, length,
		address, input ready);
	modport sink (input valid, action, byte_value, key_first, key_second, length,
		address, output ready);
endinterface

interface vpdib_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        status;

	modport source (output valid, read_data, status, input ready);
	modport sink (input valid, read_data, status, output ready);
endinterface

>>> rtl/vpdib_mem.sv
// ----------------------------------------------------------------------------
// vpdib_mem
// Dword-wide image memory with one byte-lane write port and one read port.
// ----------------------------------------------------------------------------
module vpdib_mem #(
	parameter int unsigned ROWS = 256
) (
	input  logic                      clk,
	input  vpdib_pkg::mem_wr_t        wr,
	input  logic [$clog2(ROWS)-1:0]   wr_row,
	input  logic                      rd_en,
	input  logic [$clog2(ROWS)-1:0]   rd_row,
	output logic [31:0]               rd_data
);

	logic [31:0] mem [ROWS];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (wr.we && (wr.lane == 2'(i))) begin
				mem[wr_row][8*i +: 8] <= wr.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_row];
		end
	end

endmodule

>>> rtl/pci_vpd_image_builder_unit.sv
// ----------------------------------------------------------------------------
// pci_vpd_image_builder_unit
// Builds a PCI VPD image in a byte-lane memory and serves dword reads.
// ----------------------------------------------------------------------------
// Usage: commands arrive as beats on the cmd channel (valid/ready); every
// command returns exactly one beat on the rsp channel carrying read_data
// (nonzero only for a read) and status (the overflow flag after the command).
// The block works on one command at a time. cmd.ready is high while the
// sequencer is idle, even if the previous response still waits in the
// output register; a finished command waits in its done step until that
// register is free, so a stalled receiver holds back only the next result.
// A write command steps through its bytes in the write step, and a read
// passes through the read step; a begin, and a finish with no section, go
// straight to the done step, which loads the response. The next command is
// taken once the sequencer is back in its idle step. The image memory's
// single write port takes one byte per cycle; its read data is registered.
// Reset (and the begin command) clears the write pointer and all flags. No
// clearing pass is needed: every byte is written in order at the write
// pointer (the length backpatch lands behind it), so bytes at or past the
// write pointer read as zero without touching the memory.
// ----------------------------------------------------------------------------
module pci_vpd_image_builder_unit #(
	parameter int unsigned IMAGE_BYTES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	vpdib_cmd_if.sink          cmd,
	vpdib_rsp_if.source        rsp
);

	localparam int unsigned ROWS = (IMAGE_BYTES + 3) / 4;
	localparam int unsigned RW   = $clog2(ROWS);
	localparam int unsigned WP_W = vpdib_pkg::WP_W;
	localparam logic [WP_W-1:0] LIMIT = WP_W'(IMAGE_BYTES);

	vpdib_pkg::state_t state_q, state_d;

	// Builder state kept in flops beside the memory.
	logic [WP_W-1:0] wp_q;
	logic [WP_W-1:0] ro_hdr_q;
	logic [WP_W-1:0] ro_start_q;
	logic [7:0]      sum_q;
	logic            has_id_q;
	logic            has_ro_q;
	logic            ovf_q;

	// Latched command.
	vpdib_pkg::action_t act_q;
	logic [7:0]  byte_q;
	logic [7:0]  key1_q;
	logic [7:0]  key2_q;
	logic [15:0] len_q;
	logic [14:0] addr_q;
	logic [2:0]  step_q;
	logic [31:0] res_data_q;

	logic [31:0] rsp_data_q;
	logic        rsp_status_q;
	logic        rsp_valid_q;

	logic               accept;
	vpdib_pkg::action_t cmd_act;
	logic               load_rsp;

	// Current byte of the sequence.
	logic [7:0]  op_byte;
	logic        op_put;
	logic        op_last;
	logic [15:0] rolen;
	logic [17:0] wr_pos;
	logic [WP_W-1:0] wp_inc;

	vpdib_pkg::mem_wr_t mem_wr;
	logic        rd_en;
	logic [31:0] rd_data;
	logic [31:0] rd_masked;
	logic [WP_W-1:0] lane_pos [4];

	assign cmd_act = vpdib_pkg::action_t'(cmd.action);
	assign accept  = cmd.valid && cmd.ready;
	assign rd_en   = accept && (cmd_act == vpdib_pkg::ACT_READ);

	assign rolen  = 16'(wp_q + WP_W'(4) - ro_start_q);
	assign wp_inc = (wp_q < vpdib_pkg::WP_MAX) ? wp_q + WP_W'(1) : wp_q;

	// Byte and target of the current step.
	always_comb begin
		op_byte = '0;
		op_put  = 1'b0;
		op_last = 1'b1;
		case (act_q)
			vpdib_pkg::ACT_ID_HEADER: begin
				op_last = (step_q == vpdib_pkg::HDR_B2);
				case (step_q)
					vpdib_pkg::HDR_B0: op_byte = vpdib_pkg::TAG_ID;
					vpdib_pkg::HDR_B1: op_byte = len_q[7:0];
					default:           op_byte = len_q[15:8];
				endcase
			end
			vpdib_pkg::ACT_RO_HEADER: begin
				op_last = (step_q == vpdib_pkg::HDR_B2);
				op_byte = (step_q == vpdib_pkg::HDR_B0) ? vpdib_pkg::TAG_RO : 8'h00;
			end
			vpdib_pkg::ACT_KEY_HEADER: begin
				op_last = (step_q == vpdib_pkg::HDR_B2);
				case (step_q)
					vpdib_pkg::HDR_B0: op_byte = key1_q;
					vpdib_pkg::HDR_B1: op_byte = key2_q;
					default: op_byte = (len_q[15:8] != 8'h00) ? vpdib_pkg::LEN_CLIP
						: len_q[7:0];
				endcase
			end
			vpdib_pkg::ACT_FINISH: begin
				op_last = (step_q == vpdib_pkg::FIN_END_TAG);
				case (step_q)
					vpdib_pkg::FIN_PATCH_LO: begin
						op_put  = 1'b1;
						op_byte = rolen[7:0];
					end
					vpdib_pkg::FIN_PATCH_HI: begin
						op_put  = 1'b1;
						op_byte = rolen[15:8];
					end
					vpdib_pkg::FIN_KEY_R:    op_byte = vpdib_pkg::KEY_R;
					vpdib_pkg::FIN_KEY_V:    op_byte = vpdib_pkg::KEY_V;
					vpdib_pkg::FIN_RV_LEN:   op_byte = vpdib_pkg::RV_LEN;
					vpdib_pkg::FIN_CHECKSUM: op_byte = 8'(~sum_q + 8'd1);
					default:                 op_byte = vpdib_pkg::TAG_END;
				endcase
			end
			default: op_byte = byte_q;
		endcase
	end

	// Backpatch bytes go behind the length tag, everything else at the pointer.
	always_comb begin
		if (op_put) begin
			wr_pos = {1'b0, ro_hdr_q} + ((step_q == vpdib_pkg::FIN_PATCH_LO) ? 18'd1 : 18'd2);
		end else begin
			wr_pos = {1'b0, wp_q};
		end
	end

	assign mem_wr.we   = (state_q == vpdib_pkg::ST_WRITE) && (wr_pos < {1'b0, LIMIT});
	assign mem_wr.lane = wr_pos[1:0];
	assign mem_wr.data = op_byte;

	vpdib_mem #(
		.ROWS (ROWS)
	) u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.wr_row  (wr_pos[RW+1:2]),
		.rd_en   (rd_en),
		.rd_row  (cmd.address[RW+1:2]),
		.rd_data (rd_data)
	);

	// Bytes at or past the write pointer have not been written since begin.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lane_pos[i]       = {2'b00, addr_q[14:2], 2'(i)};
			rd_masked[8*i +: 8] = (lane_pos[i] < wp_q) ? rd_data[8*i +: 8] : 8'h00;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d  = state_q;
		load_rsp = 1'b0;
		cmd.ready = (state_q == vpdib_pkg::ST_IDLE);
		case (state_q)
			vpdib_pkg::ST_IDLE: begin
				if (accept) begin
					case (cmd_act)
						vpdib_pkg::ACT_BEGIN: state_d = vpdib_pkg::ST_DONE;
						vpdib_pkg::ACT_READ:  state_d = vpdib_pkg::ST_READ;
						vpdib_pkg::ACT_FINISH: begin
							state_d = (has_id_q || has_ro_q) ? vpdib_pkg::ST_WRITE
								: vpdib_pkg::ST_DONE;
						end
						default: state_d = vpdib_pkg::ST_WRITE;
					endcase
				end
			end
			vpdib_pkg::ST_WRITE: begin
				if (op_last) begin
					state_d = vpdib_pkg::ST_DONE;
				end
			end
			vpdib_pkg::ST_READ: state_d = vpdib_pkg::ST_DONE;
			vpdib_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = vpdib_pkg::ST_IDLE;
				end
			end
			default: state_d = vpdib_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vpdib_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Builder state: pointer, running sum, section marks, overflow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			ro_hdr_q   <= '0;
			ro_start_q <= '0;
			sum_q      <= '0;
			has_id_q   <= 1'b0;
			has_ro_q   <= 1'b0;
			ovf_q      <= 1'b0;
			step_q     <= '0;
		end else begin
			if (accept) begin
				if (cmd_act == vpdib_pkg::ACT_FINISH) begin
					step_q <= has_ro_q ? vpdib_pkg::FIN_PATCH_LO : vpdib_pkg::FIN_END_TAG;
				end else begin
					step_q <= vpdib_pkg::HDR_B0;
				end
				if (cmd_act == vpdib_pkg::ACT_BEGIN) begin
					wp_q       <= '0;
					ro_hdr_q   <= '0;
					ro_start_q <= '0;
					sum_q      <= '0;
					has_id_q   <= 1'b0;
					has_ro_q   <= 1'b0;
					ovf_q      <= 1'b0;
				end
			end else if (state_q == vpdib_pkg::ST_WRITE) begin
				step_q <= step_q + 3'd1;
				sum_q  <= sum_q + op_byte;
				if (!op_put) begin
					wp_q <= wp_inc;
					if (!(wp_q < LIMIT)) begin
						ovf_q <= 1'b1;
					end
				end
				if ((act_q == vpdib_pkg::ACT_RO_HEADER) && (step_q == vpdib_pkg::HDR_B0)) begin
					ro_hdr_q <= wp_q;
				end
				if ((act_q == vpdib_pkg::ACT_RO_HEADER) && (step_q == vpdib_pkg::HDR_B2)) begin
					ro_start_q <= wp_inc;
					has_ro_q   <= 1'b1;
				end
				if (act_q == vpdib_pkg::ACT_ID_HEADER) begin
					has_id_q <= 1'b1;
				end
			end
		end
	end

	// Command payload and read result.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= cmd_act;
			byte_q     <= cmd.byte_value;
			key1_q     <= cmd.key_first;
			key2_q     <= cmd.key_second;
			len_q      <= cmd.length;
			addr_q     <= cmd.address;
			res_data_q <= '0;
		end else if (state_q == vpdib_pkg::ST_READ) begin
			res_data_q <= (ovf_q || !({2'b00, addr_q} < LIMIT)) ? 32'h0 : rd_masked;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_data_q   <= res_data_q;
			rsp_status_q <= ovf_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_data_q;
	assign rsp.status    = rsp_status_q;

	// The memory is never written outside the image.
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.we |-> (wr_pos < {1'b0, LIMIT}))
		else $error("image write outside the image");

	// Overflow only clears on a begin command.
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(ovf_q && !(accept && (cmd_act == vpdib_pkg::ACT_BEGIN))) |=> ovf_q)
		else $error("overflow flag dropped without begin");

	// The write pointer never moves backward except on begin.
	a_wp_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && (cmd_act == vpdib_pkg::ACT_BEGIN)) |=> (wp_q >= $past(wp_q)))
		else $error("write pointer moved backward");

	// A read after overflow returns zero.
	a_read_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == vpdib_pkg::ST_READ) && ovf_q) |=> (res_data_q == 32'h0))
		else $error("read returned data while overflowed");

	// A response is loaded only from the done step.
	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp_valid_q && $past(state_q != vpdib_pkg::ST_DONE)) |=> !rsp_valid_q
		|| $past(state_q == vpdib_pkg::ST_DONE))
		else $error("response loaded outside the done step");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the VPD image builder. Command beats are scored
// against a cycle-free shadow of the image that predicts one response per
// command. Directed commands and an image filled to capacity each open a run
// of randomly shaped images; a third run follows; three idling mixes in turn.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned IMAGE_BYTES = 1024;
	localparam int unsigned SH_W = $clog2(IMAGE_BYTES);
	// Cycles to linger after the last response; the slowest command is a finish.
	localparam int unsigned TAIL_CYCLES = 40;

	// One response beat as the shadow predicts it.
	typedef struct packed {
		logic [31:0] read_data;
		logic        status;
	} vpd_rsp_t;

	logic clk;
	logic arst_n;

	vpdib_cmd_if cmd_ch ();
	vpdib_rsp_if rsp_ch ();

	pci_vpd_image_builder_unit #(
		.IMAGE_BYTES (IMAGE_BYTES)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// ------------------------------------------------------------------
	// Shadow of the image and of the builder's bookkeeping.
	// ------------------------------------------------------------------
	logic [7:0]      img_shadow [IMAGE_BYTES];
	logic [vpdib_pkg::WP_W-1:0] img_wr_ptr;
	int unsigned     ro_tag_pos;
	int unsigned     ro_body_pos;
	logic [7:0]      img_sum;
	logic            seen_id;
	logic            seen_ro;
	logic            img_overflow;

	// Responses still owed by the block, oldest first.
	vpd_rsp_t    rsp_expected_q [$];
	int unsigned error_count;
	int unsigned items_sent;
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;

	initial begin : clock_gen
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom);
	endfunction

	function automatic logic [15:0] rnd_len();
		return 16'($urandom);
	endfunction

	function automatic logic [14:0] rnd_addr();
		return 15'($urandom);
	endfunction

	// A begin command and reset both leave an all-zero image behind.
	function automatic void shadow_clear();
		img_shadow   = '{default: 8'h00};
		img_wr_ptr   = '0;
		ro_tag_pos   = 0;
		ro_body_pos  = 0;
		img_sum      = 8'h00;
		seen_id      = 1'b0;
		seen_ro      = 1'b0;
		img_overflow = 1'b0;
	endfunction

	// Append one byte at the write pointer. A byte that does not fit is
	// dropped and flags the overflow, but it still counts in the sum and
	// still moves the pointer, which stops at its all-ones value.
	function automatic void shadow_emit(input logic [7:0] v);
		if (img_wr_ptr < IMAGE_BYTES) begin
			img_shadow[img_wr_ptr[SH_W-1:0]] = v;
		end else begin
			img_overflow = 1'b1;
		end
		img_sum = img_sum + v;
		if (img_wr_ptr != vpdib_pkg::WP_MAX) begin
			img_wr_ptr = img_wr_ptr + 1'b1;
		end
	endfunction

	// The length backpatch writes behind the pointer; outside the image
	// it is simply lost.
	function automatic void shadow_patch(input int unsigned pos, input logic [7:0] v);
		if (pos < IMAGE_BYTES) begin
			img_shadow[pos[SH_W-1:0]] = v;
		end
	endfunction

	function automatic logic [7:0] shadow_byte(input int unsigned pos);
		return (pos < IMAGE_BYTES) ? img_shadow[pos[SH_W-1:0]] : 8'h00;
	endfunction

	// Apply one accepted command to the shadow and return the response
	// that it must produce.
	function automatic vpd_rsp_t predict_beat(input vpdib_pkg::action_t act,
			input logic [7:0] bval, input logic [7:0] k1, input logic [7:0] k2,
			input logic [15:0] len, input logic [14:0] addr);
		vpd_rsp_t    r;
		int unsigned span;
		int unsigned base;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [7:0]  csum;
		r.read_data = '0;
		case (act)
			vpdib_pkg::ACT_BEGIN: begin
				shadow_clear();
			end
			vpdib_pkg::ACT_ID_HEADER: begin
				shadow_emit(vpdib_pkg::TAG_ID);
				shadow_emit(len[7:0]);
				shadow_emit(len[15:8]);
				seen_id = 1'b1;
			end
			vpdib_pkg::ACT_ID_BYTE, vpdib_pkg::ACT_VALUE_BYTE: begin
				shadow_emit(bval);
			end
			vpdib_pkg::ACT_RO_HEADER: begin
				// A later read-only header takes over the recorded positions.
				ro_tag_pos = 32'(img_wr_ptr);
				shadow_emit(vpdib_pkg::TAG_RO);
				shadow_emit(8'h00);
				shadow_emit(8'h00);
				ro_body_pos = 32'(img_wr_ptr);
				seen_ro = 1'b1;
			end
			vpdib_pkg::ACT_KEY_HEADER: begin
				shadow_emit(k1);
				shadow_emit(k2);
				shadow_emit((len > 16'h00FF) ? vpdib_pkg::LEN_CLIP : len[7:0]);
			end
			vpdib_pkg::ACT_FINISH: begin
				if (seen_ro) begin
					// The section length covers the four bytes of the RV entry
					// that are about to follow.
					span = 32'(img_wr_ptr) + 32'd4 - ro_body_pos;
					lo   = span[7:0];
					hi   = span[15:8];
					shadow_patch(ro_tag_pos + 1, lo);
					shadow_patch(ro_tag_pos + 2, hi);
					img_sum = img_sum + lo + hi;
					shadow_emit(vpdib_pkg::KEY_R);
					shadow_emit(vpdib_pkg::KEY_V);
					shadow_emit(vpdib_pkg::RV_LEN);
					csum = ~img_sum + 8'd1;
					shadow_emit(csum);
				end
				if (seen_id || seen_ro) begin
					shadow_emit(vpdib_pkg::TAG_END);
				end
			end
			default: begin
				// Read: nothing comes back once the image has overflowed.
				if (!img_overflow && addr < IMAGE_BYTES) begin
					base = 32'({addr[14:2], 2'b00});
					r.read_data = {shadow_byte(base + 3), shadow_byte(base + 2),
						shadow_byte(base + 1), shadow_byte(base)};
				end
			end
		endcase
		r.status = img_overflow;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// ------------------------------------------------------------------
	// Command side. The caller is always at a rising edge. A random gap
	// comes before each beat; valid is lowered only while idling, so a
	// back-to-back beat keeps valid high through the edge.
	// ------------------------------------------------------------------
	task automatic send_cmd(input vpdib_pkg::action_t act, input logic [7:0] bval,
			input logic [7:0] k1, input logic [7:0] k2, input logic [15:0] len,
			input logic [14:0] addr);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.action     <= act;
		cmd_ch.byte_value <= bval;
		cmd_ch.key_first  <= k1;
		cmd_ch.key_second <= k2;
		cmd_ch.length     <= len;
		cmd_ch.address    <= addr;
		do begin
			@(posedge clk);
		end while (!cmd_ch.ready);
		rsp_expected_q.push_back(predict_beat(act, bval, k1, k2, len, addr));
		items_sent++;
	endtask

	// Hold the command side off until every owed response is back. The
	// first edge is always waited so that valid never sees two updates in
	// one step.
	task automatic wait_for_results();
		cmd_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (rsp_expected_q.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Response side: random back-pressure and the scoreboard.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin : rsp_check
		vpd_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_expected_q.size() == 0) begin
				report_mismatch("response beat with nothing owed", rsp_ch.read_data, '0);
			end else begin
				want = rsp_expected_q.pop_front();
				if (rsp_ch.read_data !== want.read_data) begin
					report_mismatch("read_data", rsp_ch.read_data, want.read_data);
				end
				if (rsp_ch.status !== want.status) begin
					report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Field extremes, every command, clipping, reads past the written
	// part and past the image, a repeated finish and an empty finish.
	task automatic test_directed();
		send_cmd(vpdib_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd0);
		send_cmd(vpdib_pkg::ACT_BEGIN, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd0);
		send_cmd(vpdib_pkg::ACT_ID_HEADER, 8'h00, 8'h00, 8'h00, 16'hFFFF, 15'd0);
		send_cmd(vpdib_pkg::ACT_ID_BYTE, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd0);
		send_cmd(vpdib_pkg::ACT_ID_BYTE, 8'hFF, 8'h00, 8'h00, 16'h0000, 15'd0);
		send_cmd(vpdib_pkg::ACT_RO_HEADER, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd0);
		// Value lengths around the clip point.
		send_cmd(vpdib_pkg::ACT_KEY_HEADER, 8'h00, 8'hFF, 8'h00, 16'd300, 15'd0);
		send_cmd(vpdib_pkg::ACT_VALUE_BYTE, 8'hA5, 8'h00, 8'h00, 16'h0000, 15'd0);
		send_cmd(vpdib_pkg::ACT_KEY_HEADER, 8'h00, 8'h00, 8'hFF, 16'h0000, 15'd0);
		send_cmd(vpdib_pkg::ACT_KEY_HEADER, 8'h00, 8'h50, 8'h4E, 16'd255, 15'd0);
		send_cmd(vpdib_pkg::ACT_KEY_HEADER, 8'h00, 8'h53, 8'h4E, 16'd256, 15'd0);
		send_cmd(vpdib_pkg::ACT_FINISH, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd0);
		// The image is now 26 bytes; unaligned addresses read the aligned dword.
		send_cmd(vpdib_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd0);
		send_cmd(vpdib_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd5);
		send_cmd(vpdib_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd14);
		send_cmd(vpdib_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd18);
		send_cmd(vpdib_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd23);
		send_cmd(vpdib_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd27);
		send_cmd(vpdib_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd1023);
		send_cmd(vpdib_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd1024);
		send_cmd(vpdib_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 16'h0000, 15'h7FFF);
		// A second finish appends another checksum entry and end tag.
		send_cmd(vpdib_pkg::ACT_FINISH, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd0);
		send_cmd(vpdib_pkg::ACT_READ, 8'h00, 8'h00, 8'h00, 16'h0000, 15'd28);
		// With no section at all a finish writes nothing.
		send_cmd(vpdib_pkg::ACT_BEGIN, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 15'h7FFF);
		send_cmd(vpdib_pkg::ACT_FINISH, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 15'h7FFF);
		send_cmd(vpdib_pkg::ACT_READ, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 15'd0);
	endtask

	// Fill the image so that the final end tag lands in its last byte,
	// read the top of it back, then push one byte over the edge.
	task automatic test_capacity();
		send_cmd(vpdib_pkg::ACT_BEGIN, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(),
			rnd_addr());
		send_cmd(vpdib_pkg::ACT_ID_HEADER, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(),
			rnd_addr());
		// 3 + 337 * 3 + 2 = 1016 bytes before the read-only section.
		repeat (337) begin
			send_cmd(vpdib_pkg::ACT_KEY_HEADER, rnd_byte(), rnd_byte(), rnd_byte(),
				rnd_len(), rnd_addr());
		end
		repeat (2) begin
			send_cmd(vpdib_pkg::ACT_VALUE_BYTE, rnd_byte(), rnd_byte(), rnd_byte(),
				rnd_len(), rnd_addr());
		end
		send_cmd(vpdib_pkg::ACT_RO_HEADER, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(),
			rnd_addr());
		send_cmd(vpdib_pkg::ACT_FINISH, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(),
			rnd_addr());
		send_cmd(vpdib_pkg::ACT_READ, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(), 15'd1012);
		send_cmd(vpdib_pkg::ACT_READ, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(), 15'd1016);
		send_cmd(vpdib_pkg::ACT_READ, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(), 15'd1020);
		send_cmd(vpdib_pkg::ACT_READ, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(), 15'd1023);
		send_cmd(vpdib_pkg::ACT_READ, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(), 15'd1024);
		send_cmd(vpdib_pkg::ACT_READ, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(), 15'd0);
		// One byte too many: the flag sticks and every read is zero.
		send_cmd(vpdib_pkg::ACT_VALUE_BYTE, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(),
			rnd_addr());
		send_cmd(vpdib_pkg::ACT_READ, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(), 15'd1020);
		send_cmd(vpdib_pkg::ACT_FINISH, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(),
			rnd_addr());
		send_cmd(vpdib_pkg::ACT_READ, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(), 15'd0);
		// Begin clears the flag again.
		send_cmd(vpdib_pkg::ACT_BEGIN, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(),
			rnd_addr());
		send_cmd(vpdib_pkg::ACT_READ, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(), 15'd0);
	endtask

	// One well-formed image with random content, sometimes bent: a
	// missing begin (images pile up), lengths that do not match the bytes,
	// repeated headers and finishes, a missing finish, and bursts of noise.
	task automatic build_random_image();
		int unsigned n;
		int unsigned keys;
		logic [15:0] len;
		if ($urandom_range(9) != 0) begin
			send_cmd(vpdib_pkg::ACT_BEGIN, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(),
				rnd_addr());
		end
		if ($urandom_range(9) < 7) begin
			n   = $urandom_range(0, 6);
			len = ($urandom_range(1) != 0) ? 16'(n) : rnd_len();
			send_cmd(vpdib_pkg::ACT_ID_HEADER, rnd_byte(), rnd_byte(), rnd_byte(), len,
				rnd_addr());
			repeat (n) begin
				send_cmd(vpdib_pkg::ACT_ID_BYTE, rnd_byte(), rnd_byte(), rnd_byte(),
					rnd_len(), rnd_addr());
			end
		end
		if ($urandom_range(9) < 8) begin
			send_cmd(vpdib_pkg::ACT_RO_HEADER, rnd_byte(), rnd_byte(), rnd_byte(),
				rnd_len(), rnd_addr());
			keys = $urandom_range(0, 3);
			repeat (keys) begin
				n   = $urandom_range(0, 5);
				len = ($urandom_range(2) != 0) ? 16'(n) : rnd_len();
				send_cmd(vpdib_pkg::ACT_KEY_HEADER, rnd_byte(), rnd_byte(), rnd_byte(),
					len, rnd_addr());
				repeat (n) begin
					send_cmd(vpdib_pkg::ACT_VALUE_BYTE, rnd_byte(), rnd_byte(), rnd_byte(),
						rnd_len(), rnd_addr());
				end
			end
			if ($urandom_range(6) == 0) begin
				send_cmd(vpdib_pkg::ACT_RO_HEADER, rnd_byte(), rnd_byte(), rnd_byte(),
					rnd_len(), rnd_addr());
			end
		end
		if ($urandom_range(9) != 0) begin
			send_cmd(vpdib_pkg::ACT_FINISH, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(),
				rnd_addr());
		end
		if ($urandom_range(4) == 0) begin
			send_cmd(vpdib_pkg::ACT_FINISH, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(),
				rnd_addr());
		end
		// Reads mostly cover the written part and just past it.
		repeat ($urandom_range(2, 6)) begin
			send_cmd(vpdib_pkg::ACT_READ, rnd_byte(), rnd_byte(), rnd_byte(), rnd_len(),
				($urandom_range(9) == 0) ? rnd_addr() :
				15'($urandom_range(0, int'(img_wr_ptr) + 4)));
		end
		if ($urandom_range(5) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				send_cmd(vpdib_pkg::action_t'($urandom_range(0, 7)), rnd_byte(), rnd_byte(),
					rnd_byte(), rnd_len(), rnd_addr());
			end
		end
	endtask

	task automatic test_random_images(input int unsigned count);
		int unsigned goal;
		goal = items_sent + count;
		while (items_sent < goal) begin
			build_random_image();
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence of the run.
	// ------------------------------------------------------------------
	initial begin : main_flow
		error_count  = 0;
		items_sent   = 0;
		src_idle_pct = 32;
		snk_idle_pct = 67;
		shadow_clear();
		arst_n            <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.action     <= vpdib_pkg::ACT_BEGIN;
		cmd_ch.byte_value <= 8'h00;
		cmd_ch.key_first  <= 8'h00;
		cmd_ch.key_second <= 8'h00;
		cmd_ch.length     <= 16'h0000;
		cmd_ch.address    <= 15'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Slow receiver first.
		test_directed();
		test_random_images(170);
		wait_for_results();

		// Then a slow sender.
		src_idle_pct = 67;
		snk_idle_pct = 32;
		test_capacity();
		test_random_images(170);
		wait_for_results();

		// Finally full throughput on both sides.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_images(170);
		wait_for_results();

		// Linger so that a stray extra beat would still be caught.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("[pci_vpd_image_builder_unit] OK");
		end else begin
			$display("[pci_vpd_image_builder_unit] ERROR");
		end
		$finish;
	end

	// Far beyond the slowest correct run.
	initial begin : watchdog
		#5_000_000;
		$display("[pci_vpd_image_builder_unit] ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/vpdib_pkg.sv
rtl/vpdib_if.sv
rtl/vpdib_mem.sv
rtl/pci_vpd_image_builder_unit.sv
bench/tb_top.sv
